// File: src/sfla_pkg.sv
// ----------------------------------------------------------------------------
// sfla_pkg: shared types and codes for the slot free list allocator.
// Holds the command and result beat structs, the operation, status and
// membership codes, the controller state type and the control bundles.
// ----------------------------------------------------------------------------
package sfla_pkg;

	localparam int SLOT_W  = 8;
	localparam int COUNT_W = 9;

	typedef enum logic [1:0] {
		MODE_ALLOC  = 2'd0,
		MODE_FREE   = 2'd1,
		MODE_ADD    = 2'd2,
		MODE_REMOVE = 2'd3
	} sfla_mode_t;

	typedef enum logic [1:0] {
		STS_OK           = 2'd0,
		STS_NO_FREE      = 2'd1,
		STS_BAD_INDEX    = 2'd2,
		STS_WRONG_MEMBER = 2'd3
	} sfla_status_t;

	typedef enum logic [1:0] {
		MEM_NONE  = 2'd0,
		MEM_FREE  = 2'd1,
		MEM_ALLOC = 2'd2
	} sfla_member_t;

	typedef enum logic [1:0] {
		S_SWEEP,
		S_IDLE,
		S_EXEC,
		S_LINK
	} sfla_state_t;

	typedef struct packed {
		logic [1:0]        mode;
		logic [SLOT_W-1:0] slot_index;
	} sfla_in_t;

	typedef struct packed {
		logic [SLOT_W-1:0]  slot;
		logic [1:0]         status;
		logic [COUNT_W-1:0] free_count;
	} sfla_out_t;

	typedef struct packed {
		logic accept;
		logic sweep;
		logic exec;
		logic link;
	} sfla_cmd_t;

	typedef struct packed {
		logic sweep_last;
		logic need_link;
	} sfla_stat_t;

endpackage

// File: src/sfla_ram.sv
// ----------------------------------------------------------------------------
// sfla_ram: generic simple dual-port RAM.
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module sfla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: src/sfla_ctrl.sv
// ----------------------------------------------------------------------------
// sfla_ctrl: sequencing state machine of the slot free list allocator.
// Runs the initialisation sweep, then reads, executes and, for appends,
// finishes the link of each accepted command beat.
// ----------------------------------------------------------------------------
module sfla_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                cfg_wr_en,
	input  sfla_pkg::sfla_stat_t stat,
	output sfla_pkg::sfla_cmd_t  cmd,
	output logic                busy
);

	import sfla_pkg::*;

	sfla_state_t state_q;
	sfla_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd     = '0;
		busy    = 1'b1;
		state_d = state_q;
		case (state_q)
			S_SWEEP: begin
				cmd.sweep = 1'b1;
				if (stat.sweep_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.accept = 1'b1;
					state_d    = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = stat.need_link ? S_LINK : S_IDLE;
			end
			S_LINK: begin
				cmd.link = 1'b1;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (cfg_wr_en) begin
			state_d = S_SWEEP;
		end
	end

endmodule

// File: src/sfla_dp.sv
// ----------------------------------------------------------------------------
// sfla_dp: datapath of the slot free list allocator.
// Holds the link and membership RAMs, the list head, tail and length, the
// slot count and the result register, and applies each command's updates.
// ----------------------------------------------------------------------------
module sfla_dp #(
	parameter int MAX_SLOTS = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [sfla_pkg::COUNT_W-1:0]      cfg_wr_data,
	input  sfla_pkg::sfla_in_t                cmd_in,
	input  sfla_pkg::sfla_cmd_t               cmd,
	output sfla_pkg::sfla_stat_t              stat,
	output sfla_pkg::sfla_out_t               result,
	output logic                              result_valid
);

	import sfla_pkg::*;

	localparam int AW = $clog2(MAX_SLOTS);
	localparam logic [COUNT_W-1:0] CNT_LIMIT = COUNT_W'(MAX_SLOTS > 256 ? 256 : MAX_SLOTS);
	localparam logic [COUNT_W-1:0] CNT_MAX   = COUNT_W'(MAX_SLOTS > 511 ? 511 : MAX_SLOTS);

	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] total_q;
	logic [COUNT_W-1:0] sweep_q;
	logic [AW-1:0]      head_q;
	logic [AW-1:0]      tail_q;
	logic [1:0]         op_mode_q;
	logic [SLOT_W-1:0]  op_idx_q;
	sfla_out_t          res_q;
	logic               res_valid_q;

	logic [COUNT_W-1:0] cfg_count;
	logic [AW-1:0]      rd_addr;
	logic [AW-1:0]      rd_next;
	logic [AW-1:0]      rd_prev;
	logic [1:0]         rd_mem;

	logic [AW-1:0]      idx_a;
	logic               bad_idx;
	logic               do_unlink;
	logic               do_append;
	logic [AW-1:0]      unl_idx;
	logic [AW-1:0]      head_d;
	logic [AW-1:0]      tail_d;
	logic [COUNT_W-1:0] total_d;
	logic [SLOT_W-1:0]  slot_d;
	logic [1:0]         status_d;

	logic               ex_nx_we;
	logic [AW-1:0]      ex_nx_addr;
	logic [AW-1:0]      ex_nx_data;
	logic               ex_pv_we;
	logic [AW-1:0]      ex_pv_addr;
	logic [AW-1:0]      ex_pv_data;
	logic               ex_mb_we;
	logic [AW-1:0]      ex_mb_addr;
	logic [1:0]         ex_mb_data;

	logic               nx_we;
	logic [AW-1:0]      nx_addr;
	logic [AW-1:0]      nx_data;
	logic               pv_we;
	logic [AW-1:0]      pv_addr;
	logic [AW-1:0]      pv_data;
	logic               mb_we;
	logic [AW-1:0]      mb_addr;
	logic [1:0]         mb_data;

	logic [AW-1:0]      sw_addr;
	logic [AW-1:0]      sw_next;
	logic [AW-1:0]      sw_prev;

	always_comb begin
		if (cfg_wr_data == '0) begin
			cfg_count = COUNT_W'(1);
		end else if (32'(cfg_wr_data) > 32'(MAX_SLOTS)) begin
			cfg_count = CNT_MAX;
		end else begin
			cfg_count = cfg_wr_data;
		end
	end

	assign rd_addr = (cmd_in.mode == MODE_ALLOC) ? head_q : AW'(cmd_in.slot_index);

	sfla_ram #(.WIDTH(AW), .DEPTH(MAX_SLOTS)) u_next_ram (
		.clk   (clk),
		.we    (nx_we),
		.waddr (nx_addr),
		.wdata (nx_data),
		.raddr (rd_addr),
		.rdata (rd_next)
	);

	sfla_ram #(.WIDTH(AW), .DEPTH(MAX_SLOTS)) u_prev_ram (
		.clk   (clk),
		.we    (pv_we),
		.waddr (pv_addr),
		.wdata (pv_data),
		.raddr (rd_addr),
		.rdata (rd_prev)
	);

	sfla_ram #(.WIDTH(2), .DEPTH(MAX_SLOTS)) u_member_ram (
		.clk   (clk),
		.we    (mb_we),
		.waddr (mb_addr),
		.wdata (mb_data),
		.raddr (rd_addr),
		.rdata (rd_mem)
	);

	assign idx_a   = AW'(op_idx_q);
	assign bad_idx = ({1'b0, op_idx_q} >= count_q);

	always_comb begin
		do_unlink  = 1'b0;
		do_append  = 1'b0;
		unl_idx    = idx_a;
		head_d     = head_q;
		tail_d     = tail_q;
		total_d    = total_q;
		slot_d     = op_idx_q;
		status_d   = STS_OK;
		ex_nx_we   = 1'b0;
		ex_nx_addr = '0;
		ex_nx_data = '0;
		ex_pv_we   = 1'b0;
		ex_pv_addr = '0;
		ex_pv_data = '0;
		ex_mb_we   = 1'b0;
		ex_mb_addr = idx_a;
		ex_mb_data = MEM_NONE;
		case (op_mode_q)
			MODE_ALLOC: begin
				if (total_q == '0) begin
					status_d = STS_NO_FREE;
					slot_d   = '0;
				end else begin
					slot_d     = SLOT_W'(head_q);
					do_unlink  = 1'b1;
					unl_idx    = head_q;
					ex_mb_we   = 1'b1;
					ex_mb_addr = head_q;
					ex_mb_data = MEM_ALLOC;
				end
			end
			MODE_FREE: begin
				if (bad_idx) begin
					status_d = STS_BAD_INDEX;
				end else if (rd_mem != MEM_ALLOC) begin
					status_d = STS_WRONG_MEMBER;
				end else begin
					do_append = 1'b1;
				end
			end
			MODE_ADD: begin
				if (bad_idx) begin
					status_d = STS_BAD_INDEX;
				end else if (rd_mem != MEM_NONE) begin
					status_d = STS_WRONG_MEMBER;
				end else begin
					do_append = 1'b1;
				end
			end
			MODE_REMOVE: begin
				if (bad_idx) begin
					status_d = STS_BAD_INDEX;
				end else if (rd_mem == MEM_FREE) begin
					do_unlink = 1'b1;
					ex_mb_we  = 1'b1;
				end else if (rd_mem == MEM_ALLOC) begin
					ex_mb_we = 1'b1;
				end else begin
					status_d = STS_WRONG_MEMBER;
				end
			end
			default: begin
				status_d = STS_OK;
			end
		endcase

		if (do_unlink) begin
			if (total_q <= COUNT_W'(1)) begin
				head_d  = '0;
				tail_d  = '0;
				total_d = '0;
			end else begin
				if (unl_idx == head_q) begin
					head_d = rd_next;
				end else begin
					ex_nx_we   = 1'b1;
					ex_nx_addr = rd_prev;
					ex_nx_data = rd_next;
				end
				if (unl_idx == tail_q) begin
					tail_d = rd_prev;
				end else begin
					ex_pv_we   = 1'b1;
					ex_pv_addr = rd_next;
					ex_pv_data = rd_prev;
				end
				total_d = total_q - COUNT_W'(1);
			end
		end

		if (do_append) begin
			if (total_q == '0) begin
				head_d = idx_a;
			end else begin
				ex_nx_we   = 1'b1;
				ex_nx_addr = tail_q;
				ex_nx_data = idx_a;
				ex_pv_we   = 1'b1;
				ex_pv_addr = idx_a;
				ex_pv_data = tail_q;
			end
			tail_d     = idx_a;
			total_d    = total_q + COUNT_W'(1);
			ex_mb_we   = 1'b1;
			ex_mb_addr = idx_a;
			ex_mb_data = MEM_FREE;
		end
	end

	assign sw_addr = AW'(sweep_q);
	assign sw_next = (sweep_q + COUNT_W'(1) < count_q) ? AW'(sweep_q + COUNT_W'(1)) : '0;
	assign sw_prev = (sweep_q != '0) ? AW'(sweep_q - COUNT_W'(1)) : '0;

	always_comb begin
		nx_we   = 1'b0;
		nx_addr = ex_nx_addr;
		nx_data = ex_nx_data;
		pv_we   = 1'b0;
		pv_addr = ex_pv_addr;
		pv_data = ex_pv_data;
		mb_we   = 1'b0;
		mb_addr = ex_mb_addr;
		mb_data = ex_mb_data;
		if (cmd.sweep) begin
			nx_we   = 1'b1;
			nx_addr = sw_addr;
			nx_data = sw_next;
			pv_we   = 1'b1;
			pv_addr = sw_addr;
			pv_data = sw_prev;
			mb_we   = 1'b1;
			mb_addr = sw_addr;
			mb_data = MEM_FREE;
		end else if (cmd.link) begin
			nx_we   = 1'b1;
			nx_addr = idx_a;
			nx_data = '0;
		end else if (cmd.exec) begin
			nx_we = ex_nx_we;
			pv_we = ex_pv_we;
			mb_we = ex_mb_we;
		end
	end

	assign stat.sweep_last = (sweep_q == count_q - COUNT_W'(1));
	assign stat.need_link  = do_append;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= CNT_LIMIT;
			head_q      <= '0;
			tail_q      <= AW'(CNT_LIMIT - COUNT_W'(1));
			total_q     <= CNT_LIMIT;
			sweep_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= cmd.exec;
			if (cfg_wr_en) begin
				count_q <= cfg_count;
				head_q  <= '0;
				tail_q  <= AW'(cfg_count - COUNT_W'(1));
				total_q <= cfg_count;
				sweep_q <= '0;
			end else begin
				if (cmd.sweep) begin
					sweep_q <= sweep_q + COUNT_W'(1);
				end
				if (cmd.exec) begin
					head_q  <= head_d;
					tail_q  <= tail_d;
					total_q <= total_d;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_mode_q <= cmd_in.mode;
			op_idx_q  <= cmd_in.slot_index;
		end
		if (cmd.exec) begin
			res_q.slot       <= slot_d;
			res_q.status     <= status_d;
			res_q.free_count <= total_d;
		end
	end

	assign result       = res_q;
	assign result_valid = res_valid_q;

endmodule

// File: src/slot_free_list_allocator.sv
// The result beat is registered in the execute state that follows acceptance.
// A command beat is accepted only in the idle state, after the last has executed;
// a successful free or add also passes through the link state, as its second write
// to the next-link RAM needs the port to itself. Reset and every slot_count write
// start an initialisation sweep, one RAM entry per cycle, with busy held high.
// The receiver cannot stall; each result beat is valid for one cycle only.
// ----------------------------------------------------------------------------
// slot_free_list_allocator: fixed-slot allocator with a FIFO free list.
// Keeps a doubly linked free list and a membership mark per slot in RAM and
// serves alloc, free, add and remove commands, one result beat per command.
// ----------------------------------------------------------------------------
module slot_free_list_allocator #(
	parameter int MAX_SLOTS = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [sfla_pkg::COUNT_W-1:0] cfg_wr_data,
	input  logic                         start,
	output logic                         busy,
	input  sfla_pkg::sfla_in_t           cmd,
	output logic                         result_valid,
	output sfla_pkg::sfla_out_t          result
);

	import sfla_pkg::*;

	localparam logic [COUNT_W-1:0] FREE_LIMIT = COUNT_W'(MAX_SLOTS > 511 ? 511 : MAX_SLOTS);

	sfla_cmd_t  ctrl_cmd;
	sfla_stat_t dp_stat;

	sfla_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cfg_wr_en (cfg_wr_en),
		.stat      (dp_stat),
		.cmd       (ctrl_cmd),
		.busy      (busy)
	);

	sfla_dp #(.MAX_SLOTS(MAX_SLOTS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.cmd_in       (cmd),
		.cmd          (ctrl_cmd),
		.stat         (dp_stat),
		.result       (result),
		.result_valid (result_valid)
	);

`ifndef ASSERT_OFF
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy did not rise after an accepted command beat");

	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result beats in consecutive cycles");

	a_no_free_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == STS_NO_FREE |->
			result.free_count == '0 && result.slot == '0)
		else $error("no-free result with non-zero slot or free count");

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.free_count <= FREE_LIMIT)
		else $error("free count above the slot limit");
`endif

endmodule

// File: sim/tb_slot_free_list_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_slot_free_list_allocator: self-checking bench for the slot allocator.
// A behavioural free list model predicts every result beat. The model and the
// block are driven with directed list operations, then with mostly well-formed
// random traffic under several slot counts and with varying gaps between
// command beats.
// ----------------------------------------------------------------------------
module tb_slot_free_list_allocator;
	import sfla_pkg::*;

	localparam int NSLOT        = 256;
	localparam int DRAIN_CYCLES = 6;

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [COUNT_W-1:0] cfg_wr_data;
	logic               start;
	logic               busy;
	sfla_in_t           cmd;
	logic               result_valid;
	sfla_out_t          result;

	slot_free_list_allocator #(
		.MAX_SLOTS(NSLOT)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.result_valid(result_valid),
		.result      (result)
	);

	logic [SLOT_W-1:0] nxt  [NSLOT];
	logic [SLOT_W-1:0] prv  [NSLOT];
	sfla_member_t      mark [NSLOT];
	logic [SLOT_W-1:0] head;
	logic [SLOT_W-1:0] tail;
	int unsigned       free_len;
	int unsigned       cur_count;
	sfla_out_t         expected_beats [$];
	int unsigned       err_cnt;
	int unsigned       idle_pct;

	function automatic void flag(string msg);
		if (err_cnt < 10) begin
			$display("ERROR at %0t: %s", $time, msg);
		end
		err_cnt++;
	endfunction

	function automatic void load_count(logic [COUNT_W-1:0] v);
		int unsigned n;
		n = (v == '0) ? 1 : ((32'(v) > NSLOT) ? NSLOT : 32'(v));
		cur_count = n;
		for (int k = 0; k < NSLOT; k++) begin
			nxt[k]  = (k + 1 < n) ? SLOT_W'(k + 1) : '0;
			prv[k]  = (k > 0 && k < n) ? SLOT_W'(k - 1) : '0;
			mark[k] = (k < n) ? MEM_FREE : MEM_NONE;
		end
		head     = '0;
		tail     = SLOT_W'(n - 1);
		free_len = n;
	endfunction

	function automatic void unlink_slot(logic [SLOT_W-1:0] i);
		logic [SLOT_W-1:0] p;
		logic [SLOT_W-1:0] n;
		p = prv[i];
		n = nxt[i];
		if (free_len <= 1) begin
			free_len = 0;
			head     = '0;
			tail     = '0;
			return;
		end
		if (i == head) head = n;
		else nxt[p] = n;
		if (i == tail) tail = p;
		else prv[n] = p;
		free_len--;
	endfunction

	function automatic void append_slot(logic [SLOT_W-1:0] i);
		if (free_len == 0) begin
			head = i;
		end else begin
			nxt[tail] = i;
			prv[i]    = tail;
		end
		nxt[i]  = '0;
		tail    = i;
		free_len++;
		mark[i] = MEM_FREE;
	endfunction

	function automatic sfla_out_t allocator_result(sfla_in_t c);
		sfla_out_t    r;
		sfla_member_t m;
		r.slot   = c.slot_index;
		r.status = STS_OK;
		if (c.mode == MODE_ALLOC) begin
			if (free_len == 0) begin
				r.status = STS_NO_FREE;
				r.slot   = '0;
			end else begin
				r.slot = head;
				unlink_slot(r.slot);
				mark[r.slot] = MEM_ALLOC;
			end
		end else if (c.slot_index >= cur_count) begin
			r.status = STS_BAD_INDEX;
		end else begin
			m = mark[c.slot_index];
			case (c.mode)
				MODE_FREE: begin
					if (m != MEM_ALLOC) r.status = STS_WRONG_MEMBER;
					else append_slot(c.slot_index);
				end
				MODE_ADD: begin
					if (m != MEM_NONE) r.status = STS_WRONG_MEMBER;
					else append_slot(c.slot_index);
				end
				default: begin
					if (m == MEM_FREE) begin
						unlink_slot(c.slot_index);
						mark[c.slot_index] = MEM_NONE;
					end else if (m == MEM_ALLOC) begin
						mark[c.slot_index] = MEM_NONE;
					end else begin
						r.status = STS_WRONG_MEMBER;
					end
				end
			endcase
		end
		r.free_count = free_len[COUNT_W-1:0];
		return r;
	endfunction

	// Picks a slot in range with either of the given marks, starting from a
	// random point; falls back to a random slot in range when none has one.
	function automatic logic [SLOT_W-1:0] find_slot(sfla_member_t a, sfla_member_t b);
		int unsigned base;
		int unsigned k;
		base = $urandom_range(cur_count - 1);
		for (k = 0; k < cur_count; k++) begin
			if (mark[(base + k) % cur_count] == a || mark[(base + k) % cur_count] == b) begin
				return SLOT_W'((base + k) % cur_count);
			end
		end
		return SLOT_W'(base);
	endfunction

	task automatic send_cmd(input sfla_mode_t m, input logic [SLOT_W-1:0] idx);
		@(negedge clk);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < idle_pct);
		end
		start <= 1'b1;
		cmd   <= '{mode: m, slot_index: idx};
		do @(posedge clk); while (busy);
		expected_beats.push_back(allocator_result(cmd));
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_slot_count(input logic [COUNT_W-1:0] v);
		drain();
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		load_count(v);
		repeat (2) @(negedge clk);
	endtask

	task automatic test_list_operations();
		idle_pct = 0;
		send_cmd(MODE_ALLOC, 8'd255);
		send_cmd(MODE_ALLOC, 8'd0);
		send_cmd(MODE_FREE, 8'd0);
		send_cmd(MODE_FREE, 8'd0);
		send_cmd(MODE_FREE, 8'd255);
		send_cmd(MODE_REMOVE, 8'd1);
		send_cmd(MODE_REMOVE, 8'd1);
		send_cmd(MODE_ADD, 8'd1);
		send_cmd(MODE_ADD, 8'd1);
		send_cmd(MODE_REMOVE, 8'd5);
		send_cmd(MODE_REMOVE, 8'd255);
	endtask

	task automatic test_tiny_list();
		set_slot_count(9'd2);
		send_cmd(MODE_ALLOC, 8'd0);
		send_cmd(MODE_ALLOC, 8'd0);
		send_cmd(MODE_ALLOC, 8'd170);
		send_cmd(MODE_FREE, 8'd2);
		send_cmd(MODE_ADD, 8'd255);
		send_cmd(MODE_REMOVE, 8'd3);
		send_cmd(MODE_FREE, 8'd1);
		send_cmd(MODE_REMOVE, 8'd1);
		send_cmd(MODE_ADD, 8'd1);
		send_cmd(MODE_REMOVE, 8'd0);
	endtask

	// A count of zero is taken as a single slot.
	task automatic test_count_floor();
		set_slot_count(9'd0);
		send_cmd(MODE_ALLOC, 8'd0);
		send_cmd(MODE_ALLOC, 8'd0);
		send_cmd(MODE_REMOVE, 8'd0);
		send_cmd(MODE_ADD, 8'd0);
		send_cmd(MODE_FREE, 8'd1);
	endtask

	task automatic test_random_traffic(input logic [COUNT_W-1:0] count, input int unsigned pct,
			input int unsigned n_items);
		sfla_mode_t        m;
		logic [SLOT_W-1:0] idx;
		int unsigned       r;
		int unsigned       lim;
		set_slot_count(count);
		idle_pct = pct;
		repeat (n_items) begin
			r = $urandom_range(99);
			if (r < 35) begin
				m   = MODE_ALLOC;
				idx = SLOT_W'($urandom);
			end else if (r < 58) begin
				m   = MODE_FREE;
				idx = find_slot(MEM_ALLOC, MEM_ALLOC);
			end else if (r < 70) begin
				m   = MODE_ADD;
				idx = find_slot(MEM_NONE, MEM_NONE);
			end else if (r < 84) begin
				m   = MODE_REMOVE;
				idx = find_slot(MEM_FREE, MEM_ALLOC);
			end else begin
				m   = sfla_mode_t'($urandom_range(3));
				lim = (cur_count + 1 > 255) ? 255 : cur_count + 1;
				idx = SLOT_W'($urandom_range(1) ? $urandom : $urandom_range(lim));
			end
			send_cmd(m, idx);
		end
	endtask

	always @(posedge clk) begin
		sfla_out_t want;
		if (arst_n && result_valid) begin
			if (expected_beats.size() == 0) begin
				flag($sformatf("result beat with no command outstanding: slot %0d status %0d free %0d",
					result.slot, result.status, result.free_count));
			end else begin
				want = expected_beats.pop_front();
				if (result.slot !== want.slot || result.status !== want.status ||
						result.free_count !== want.free_count) begin
					flag($sformatf("expected slot %0d status %0d free %0d, got slot %0d status %0d free %0d",
						want.slot, want.status, want.free_count,
						result.slot, result.status, result.free_count));
				end
			end
		end
	end

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("slot_free_list_allocator: mismatch");
		$finish;
	end

	initial begin
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		start       = 1'b0;
		cmd         = '0;
		err_cnt     = 0;
		idle_pct    = 0;
		load_count(9'd256);
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_list_operations();
		test_tiny_list();
		test_count_floor();
		test_random_traffic(9'd256, 0, 200);
		test_random_traffic(9'd12, 87, 150);
		test_random_traffic(9'd511, 22, 150);
		test_random_traffic(9'd3, 0, 80);
		test_random_traffic(9'd100, 87, 70);
		drain();

		if (err_cnt == 0) begin
			$display("slot_free_list_allocator: match");
		end else begin
			$display("slot_free_list_allocator: mismatch");
		end
		$finish;
	end

endmodule
